// ===== rtl/lpfr_pkg.sv =====
// Shared types and constants for the length-prefixed frame receiver.
// No dependencies; every other file refers to this package by scoped names.
package lpfr_pkg;

  localparam int unsigned MAX_FRAME_LIMIT = 262144;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [2:0] EV_PAYLOAD = 3'd0;
  localparam logic [2:0] EV_ACK     = 3'd1;
  localparam logic [2:0] EV_ABORT   = 3'd2;
  localparam logic [2:0] EV_STARTED = 3'd3;
  localparam logic [2:0] EV_ENDED   = 3'd4;
  localparam logic [2:0] EV_TIMEOUT = 3'd5;

  localparam logic [2:0] REG_IDLE_TMO = 3'd0;
  localparam logic [2:0] REG_HDR_TMO  = 3'd1;
  localparam logic [2:0] REG_PAY_TMO  = 3'd2;
  localparam logic [2:0] REG_MAX_LEN  = 3'd3;
  localparam logic [2:0] REG_SYNC     = 3'd4;
  localparam logic [2:0] REG_END      = 3'd5;

  localparam int CFG_DATA_W = 25;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [15:0] idle_tmo;
    logic [15:0] hdr_tmo;
    logic [15:0] pay_tmo;
    logic [24:0] max_bytes;
    logic [7:0]  sync_val;
    logic [7:0]  end_val;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  byte_val;
    logic [23:0] offset;
    logic        lof;
    logic        lor;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  function automatic result_t mk_event(input logic [2:0] ev);
    result_t r;
    r          = '0;
    r.ev       = ev;
    return r;
  endfunction

endpackage

// ===== rtl/lpfr_front.sv =====
// Front end: takes input beats, classifies the command and queues the work.
// Uses lpfr_pkg for the item type and command codes.
module lpfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_data_byte,
  output logic              q_valid,
  output lpfr_pkg::item_t   q_item,
  input  logic              q_pop
);

  lpfr_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            push;
  logic            keep;
  lpfr_pkg::op_t   op;

  always_comb begin
    keep = 1'b1;
    op   = lpfr_pkg::OP_BYTE;
    unique case (in_command)
      lpfr_pkg::CMD_BYTE:  op = lpfr_pkg::OP_BYTE;
      lpfr_pkg::CMD_TICK:  op = lpfr_pkg::OP_TICK;
      lpfr_pkg::CMD_START: op = lpfr_pkg::OP_START;
      default:             keep = 1'b0;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{op: op, data: in_data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/lpfr_engine.sv =====
// Back end: streaming state machine, header and payload tracking, timers.
// Uses lpfr_pkg; consumes queued items and emits up to two results each.
module lpfr_engine #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lpfr_pkg::cfg_t  cfg,
  input  logic            item_valid,
  input  lpfr_pkg::item_t item,
  input  logic            room,
  output logic            pop,
  output lpfr_pkg::push_t push
);

  localparam int AW = TIMER_WIDTH + 1;
  localparam logic [32:0] TMO_MAX = (33'd1 << TIMER_WIDTH) - 33'd1;
  localparam logic [AW-1:0] AGE_MAX = '1;
  localparam logic [24:0] LIMIT = 25'(lpfr_pkg::MAX_FRAME_LIMIT);

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_HDR  = 3'b010,
    PH_PAY  = 3'b100
  } phase_t;

  function automatic logic [32:0] clip_tmo(input logic [15:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > TMO_MAX) ? TMO_MAX : w;
  endfunction

  function automatic logic [AW-1:0] age_inc(input logic [AW-1:0] a);
    return (a == AGE_MAX) ? a : a + AW'(1);
  endfunction

  logic             streaming_r, streaming_nxt;
  phase_t           phase_r, phase_nxt;
  logic [1:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [23:0]      rcv_r, rcv_nxt;
  logic [AW-1:0]    idle_age_r, idle_age_nxt;
  logic [AW-1:0]    phase_age_r, phase_age_nxt;

  logic [AW-1:0]    idle_inc;
  logic [AW-1:0]    phase_inc;
  logic [31:0]      len_new;
  logic [24:0]      rcv_inc;
  logic [24:0]      lim;
  logic             last_byte;
  logic             n0, n1;
  lpfr_pkg::result_t r0, r1;

  assign pop = item_valid && room;

  always_comb begin
    streaming_nxt = streaming_r;
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    len_nxt       = len_r;
    rcv_nxt       = rcv_r;
    idle_age_nxt  = idle_age_r;
    phase_age_nxt = phase_age_r;
    n0            = 1'b0;
    n1            = 1'b0;
    r0            = '0;
    r1            = lpfr_pkg::mk_event(lpfr_pkg::EV_ACK);
    r1.lor        = 1'b1;

    idle_inc  = age_inc(idle_age_r);
    phase_inc = age_inc(phase_age_r);
    len_new   = len_r | (32'(item.data) << {hdr_cnt_r, 3'b000});
    rcv_inc   = 25'(rcv_r) + 25'd1;
    last_byte = (rcv_inc >= len_r[24:0]);
    lim       = (cfg.max_bytes > LIMIT) ? LIMIT : cfg.max_bytes;

    unique case (item.op)
      lpfr_pkg::OP_START: begin
        if (!streaming_r) begin
          streaming_nxt = 1'b1;
          phase_nxt     = PH_WAIT;
          hdr_cnt_nxt   = 2'd0;
          len_nxt       = 32'd0;
          rcv_nxt       = 24'd0;
          idle_age_nxt  = '0;
          phase_age_nxt = '0;
          n0            = 1'b1;
          r0            = lpfr_pkg::mk_event(lpfr_pkg::EV_STARTED);
        end
      end
      lpfr_pkg::OP_TICK: begin
        if (streaming_r) begin
          idle_age_nxt = idle_inc;
          unique case (phase_r)
            PH_HDR: begin
              phase_age_nxt = phase_inc;
              if (33'(phase_inc) >= clip_tmo(cfg.hdr_tmo)) begin
                phase_nxt = PH_WAIT;
              end
            end
            PH_PAY: begin
              phase_age_nxt = phase_inc;
              if (33'(phase_inc) >= clip_tmo(cfg.pay_tmo)) begin
                phase_nxt = PH_WAIT;
                n0        = 1'b1;
                r0        = lpfr_pkg::mk_event(lpfr_pkg::EV_ABORT);
              end
            end
            default: begin
              if (33'(idle_inc) > clip_tmo(cfg.idle_tmo)) begin
                streaming_nxt = 1'b0;
                phase_nxt     = PH_WAIT;
                n0            = 1'b1;
                r0            = lpfr_pkg::mk_event(lpfr_pkg::EV_TIMEOUT);
              end
            end
          endcase
        end
      end
      default: begin
        if (streaming_r) begin
          unique case (phase_r)
            PH_HDR: begin
              len_nxt     = len_new;
              hdr_cnt_nxt = hdr_cnt_r + 2'd1;
              if (hdr_cnt_r == 2'd3) begin
                if (len_new != 32'd0 && len_new <= 32'(lim)) begin
                  phase_nxt     = PH_PAY;
                  rcv_nxt       = 24'd0;
                  phase_age_nxt = '0;
                end else begin
                  phase_nxt = PH_WAIT;
                end
              end
            end
            PH_PAY: begin
              n0            = 1'b1;
              r0.ev         = lpfr_pkg::EV_PAYLOAD;
              r0.byte_val   = item.data;
              r0.offset     = rcv_r;
              r0.lof        = last_byte;
              phase_age_nxt = '0;
              if (last_byte) begin
                n1        = 1'b1;
                phase_nxt = PH_WAIT;
                rcv_nxt   = 24'd0;
              end else begin
                rcv_nxt = rcv_inc[23:0];
              end
            end
            default: begin
              idle_age_nxt = '0;
              priority if (item.data == cfg.end_val) begin
                streaming_nxt = 1'b0;
                phase_nxt     = PH_WAIT;
                n0            = 1'b1;
                r0            = lpfr_pkg::mk_event(lpfr_pkg::EV_ENDED);
              end else if (item.data == cfg.sync_val) begin
                phase_nxt     = PH_HDR;
                hdr_cnt_nxt   = 2'd0;
                len_nxt       = 32'd0;
                phase_age_nxt = '0;
              end
            end
          endcase
        end
      end
    endcase

    r0.lor = !n1;
  end

  always_comb begin
    push.push0 = pop && n0;
    push.push1 = pop && n1;
    push.res0  = r0;
    push.res1  = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      streaming_r <= 1'b0;
      phase_r     <= PH_WAIT;
      hdr_cnt_r   <= 2'd0;
      len_r       <= 32'd0;
      rcv_r       <= 24'd0;
      idle_age_r  <= '0;
      phase_age_r <= '0;
    end else if (pop) begin
      streaming_r <= streaming_nxt;
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      len_r       <= len_nxt;
      rcv_r       <= rcv_nxt;
      idle_age_r  <= idle_age_nxt;
      phase_age_r <= phase_age_nxt;
    end
  end

endmodule

// ===== rtl/lpfr_out_fifo.sv =====
// Result queue: four entries, takes up to two results a cycle, sends one beat.
// Uses lpfr_pkg for the result and push types.
module lpfr_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  lpfr_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output lpfr_pkg::result_t head
);

  lpfr_pkg::result_t mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign room      = (count_r <= 3'd2);
  assign out_valid = (count_r != 3'd0);
  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 2'(push.push0) + 2'(push.push1);
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    count_nxt  = count_r + 3'(push.push0) + 3'(push.push1) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[wr_ptr_r + 2'd1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/length_prefixed_frame_receiver_unit.sv =====
// Length-prefixed frame receiver. Takes one input beat per cycle (byte, tick
// or start) into a two-entry queue unless full; the engine handles one queued
// item per cycle, holding while the result queue has fewer than two free
// entries, and writes its results into that four-entry queue, which sends one
// beat per cycle unless stalled. An input passes the input queue and result
// queue registers before its first result. An item that ends a frame yields
// two beats, so a run of such items is bound by the single result port.
// Register writes take effect on the next item processed.
// Depends on lpfr_pkg, lpfr_front, lpfr_engine and lpfr_out_fifo.
module length_prefixed_frame_receiver_unit #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_payload_byte,
  output logic [23:0] out_byte_offset,
  output logic        out_last_of_frame,
  output logic        out_last_of_run,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [lpfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  lpfr_pkg::cfg_t    cfg_r, cfg_nxt;
  lpfr_pkg::item_t   q_item;
  lpfr_pkg::push_t   push;
  lpfr_pkg::result_t head;
  logic              q_valid;
  logic              q_pop;
  logic              room;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        lpfr_pkg::REG_IDLE_TMO: cfg_nxt.idle_tmo  = cfg_data[15:0];
        lpfr_pkg::REG_HDR_TMO:  cfg_nxt.hdr_tmo   = cfg_data[15:0];
        lpfr_pkg::REG_PAY_TMO:  cfg_nxt.pay_tmo   = cfg_data[15:0];
        lpfr_pkg::REG_MAX_LEN:  cfg_nxt.max_bytes = cfg_data[24:0];
        lpfr_pkg::REG_SYNC:     cfg_nxt.sync_val  = cfg_data[7:0];
        lpfr_pkg::REG_END:      cfg_nxt.end_val   = cfg_data[7:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_tmo  <= 16'd10000;
      cfg_r.hdr_tmo   <= 16'd1000;
      cfg_r.pay_tmo   <= 16'd2000;
      cfg_r.max_bytes <= 25'd262144;
      cfg_r.sync_val  <= 8'hFF;
      cfg_r.end_val   <= 8'h00;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lpfr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  lpfr_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_valid),
    .item       (q_item),
    .room       (room),
    .pop        (q_pop),
    .push       (push)
  );

  lpfr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_event_res     = head.ev;
  assign out_payload_byte  = head.byte_val;
  assign out_byte_offset   = head.offset;
  assign out_last_of_frame = head.lof;
  assign out_last_of_run   = head.lor;

`ifndef SYNTHESIS
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> room && q_valid)
    else $error("engine consumed an item without result space");

  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> push.push0 && push.res0.ev == lpfr_pkg::EV_PAYLOAD &&
                   push.res0.lof && push.res1.ev == lpfr_pkg::EV_ACK)
    else $error("second result is not an acknowledge after a last byte");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    push.push0 && !push.push1 |-> push.res0.lor)
    else $error("single result lacks end-of-run mark");
`endif

endmodule
